[src/fast_inverse_square_root_core_assert.svh]
// Assertion macros for the fast inverse square root core.
// Depends on a clk and an arst_n signal in the scope of use.
`ifndef FAST_INVERSE_SQUARE_ROOT_CORE_ASSERT_SVH
`define FAST_INVERSE_SQUARE_ROOT_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define FISR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define FISR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/fisr_pkg.sv]
// Shared constants, types and helper functions of the fast inverse square root core.
// No dependencies.
package fisr_pkg;

	localparam logic [31:0] GUESS_MAGIC  = 32'h5F37_5A86;
	localparam logic [31:0] CANON_NAN    = 32'h7FC0_0000;
	localparam logic [31:0] ONE_HALF     = 32'h3F00_0000;
	localparam logic [31:0] THREE_HALVES = 32'h3FC0_0000;
	localparam logic [30:0] INF_MAG      = 31'h7F80_0000;

	localparam int NUM_STAGES = 15;

	// Load enables of the three stages of one arithmetic unit.
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
	} fisr_adv_t;

	// Special-value class of an operation in flight.
	typedef struct packed {
		logic nan;
		logic inf;
		logic zero;
	} fisr_cls_t;

	function automatic logic [4:0] lzc24(input logic [23:0] v);
		logic [4:0] n;
		n = 5'd24;
		for (int i = 0; i < 24; i++) begin
			if (v[i]) n = 5'(23 - i);
		end
		return n;
	endfunction

	function automatic logic [4:0] lzc27(input logic [26:0] v);
		logic [4:0] n;
		n = 5'd27;
		for (int i = 0; i < 27; i++) begin
			if (v[i]) n = 5'(26 - i);
		end
		return n;
	endfunction

endpackage

[src/fisr_operand_if.sv]
// Input channel of the fast inverse square root core: valid/ready plus operand bits.
// No dependencies.
interface fisr_operand_if;
	logic        valid;
	logic        ready;
	logic [31:0] operand_bits;

	modport source(output valid, output operand_bits, input ready);
	modport sink(input valid, input operand_bits, output ready);
endinterface

[src/fisr_result_if.sv]
// Output channel of the fast inverse square root core: valid/ready plus result bits.
// No dependencies.
interface fisr_result_if;
	logic        valid;
	logic        ready;
	logic [31:0] result_bits;

	modport source(output valid, output result_bits, input ready);
	modport sink(input valid, input result_bits, output ready);
endinterface

[src/fisr_fmul.sv]
// Three-stage binary32 multiplier, round to nearest even, subnormals supported.
// Depends on fisr_pkg.
module fisr_fmul import fisr_pkg::*; (
	input  logic        clk,
	input  fisr_adv_t   adv,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [31:0] z
);

	// Stage 1: classify, normalize the significands
	logic             a_nan, a_inf, a_zero, b_nan, b_inf, b_zero;
	logic [23:0]      ma, mb;
	logic [4:0]       lza, lzb;
	logic signed [11:0] ea_n, eb_n;
	fisr_cls_t        cls_c;

	logic             sign_s1;
	fisr_cls_t        cls_s1;
	logic [23:0]      ma_s1, mb_s1;
	logic signed [11:0] e_s1;

	always_comb begin
		a_nan  = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
		a_inf  = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
		a_zero = (a[30:0] == 31'd0);
		b_nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
		b_inf  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
		b_zero = (b[30:0] == 31'd0);
		cls_c.nan  = a_nan | b_nan | (a_inf & b_zero) | (b_inf & a_zero);
		cls_c.inf  = a_inf | b_inf;
		cls_c.zero = a_zero | b_zero;
		ma   = {a[30:23] != 8'd0, a[22:0]};
		mb   = {b[30:23] != 8'd0, b[22:0]};
		lza  = lzc24(ma);
		lzb  = lzc24(mb);
		ea_n = $signed({4'd0, (a[30:23] == 8'd0) ? 8'd1 : a[30:23]}) - $signed({7'd0, lza});
		eb_n = $signed({4'd0, (b[30:23] == 8'd0) ? 8'd1 : b[30:23]}) - $signed({7'd0, lzb});
	end

	always_ff @(posedge clk) begin
		if (adv.s1) begin
			sign_s1 <= a[31] ^ b[31];
			cls_s1  <= cls_c;
			ma_s1   <= ma << lza;
			mb_s1   <= mb << lzb;
			e_s1    <= ea_n + eb_n - 12'sd127;
		end
	end

	// Stage 2: multiply, align the leading one to the top bit
	logic [47:0]      prod;
	logic             sign_s2;
	fisr_cls_t        cls_s2;
	logic [47:0]      m_s2;
	logic signed [11:0] e_s2;

	assign prod = ma_s1 * mb_s1;

	always_ff @(posedge clk) begin
		if (adv.s2) begin
			sign_s2 <= sign_s1;
			cls_s2  <= cls_s1;
			m_s2    <= prod[47] ? prod : {prod[46:0], 1'b0};
			e_s2    <= prod[47] ? e_s1 + 12'sd1 : e_s1;
		end
	end

	// Stage 3: denormalize if tiny, round, pack
	logic [7:0]  sh;
	logic [47:0] ms;
	logic        lost, g, st, inc, ovf;
	logic [7:0]  base;
	logic [23:0] mant;
	logic [30:0] packed_mag;
	logic [31:0] z_c;
	logic [31:0] z_s3;

	always_comb begin
		ovf = (e_s2 >= 12'sd255);
		sh  = 8'd0;
		if (e_s2 <= 12'sd0) begin
			sh   = 8'(12'sd1 - e_s2);
			base = 8'd0;
		end else begin
			base = 8'(e_s2 - 12'sd1);
		end
		ms   = m_s2 >> sh;
		lost = ((ms << sh) != m_s2);
		mant = ms[47:24];
		g    = ms[23];
		st   = (|ms[22:0]) | lost;
		inc  = g & (st | mant[0]);
		packed_mag = {base, 23'd0} + 31'(mant) + 31'(inc);
		priority if (cls_s2.nan) begin
			z_c = CANON_NAN;
		end else if (cls_s2.inf || (!cls_s2.zero && ovf)) begin
			z_c = {sign_s2, INF_MAG};
		end else if (cls_s2.zero) begin
			z_c = {sign_s2, 31'd0};
		end else begin
			z_c = {sign_s2, packed_mag};
		end
	end

	always_ff @(posedge clk) begin
		if (adv.s3) z_s3 <= z_c;
	end

	assign z = z_s3;

endmodule

[src/fisr_fadd.sv]
// Three-stage binary32 adder, round to nearest even, subnormals supported.
// Depends on fisr_pkg.
module fisr_fadd import fisr_pkg::*; (
	input  logic        clk,
	input  fisr_adv_t   adv,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [31:0] z
);

	// Stage 1: classify, order by magnitude, align the smaller operand
	logic        a_nan, a_inf, b_nan, b_inf, swap;
	logic [31:0] big, sml;
	logic [7:0]  eb, es, d;
	logic [26:0] mb27, ms27, shs;
	logic        lost;
	fisr_cls_t   cls_c;

	logic        sign_s1, sub_s1;
	fisr_cls_t   cls_s1;
	logic [26:0] mb_s1, ms_s1;
	logic [7:0]  e_s1;

	always_comb begin
		a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
		a_inf = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
		b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
		b_inf = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
		cls_c.nan  = a_nan | b_nan | (a_inf & b_inf & (a[31] ^ b[31]));
		cls_c.inf  = a_inf | b_inf;
		cls_c.zero = 1'b0;
		swap = (b[30:0] > a[30:0]);
		big  = swap ? b : a;
		sml  = swap ? a : b;
		eb   = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
		es   = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
		d    = eb - es;
		mb27 = {big[30:23] != 8'd0, big[22:0], 3'd0};
		ms27 = {sml[30:23] != 8'd0, sml[22:0], 3'd0};
		shs  = ms27 >> d;
		lost = ((shs << d) != ms27);
	end

	always_ff @(posedge clk) begin
		if (adv.s1) begin
			sign_s1 <= big[31];
			sub_s1  <= a[31] ^ b[31];
			cls_s1  <= cls_c;
			mb_s1   <= mb27;
			ms_s1   <= {shs[26:1], shs[0] | lost};
			e_s1    <= eb;
		end
	end

	// Stage 2: add or subtract magnitudes
	logic        sign_s2, sub_s2;
	fisr_cls_t   cls_s2;
	logic [27:0] sum_s2;
	logic [7:0]  e_s2;

	always_ff @(posedge clk) begin
		if (adv.s2) begin
			sign_s2 <= sign_s1;
			sub_s2  <= sub_s1;
			cls_s2  <= cls_s1;
			sum_s2  <= sub_s1 ? ({1'b0, mb_s1} - {1'b0, ms_s1})
			                  : ({1'b0, mb_s1} + {1'b0, ms_s1});
			e_s2    <= e_s1;
		end
	end

	// Stage 3: normalize (stop at the subnormal floor), round, pack
	logic [4:0]  lz, sh;
	logic [7:0]  lim;
	logic [26:0] n;
	logic [8:0]  e_n;
	logic [7:0]  base;
	logic        g, st, inc, ovf;
	logic [23:0] mant;
	logic [30:0] packed_mag;
	logic [31:0] z_c;
	logic [31:0] z_s3;

	always_comb begin
		lz  = lzc27(sum_s2[26:0]);
		lim = e_s2 - 8'd1;
		sh  = ({3'd0, lz} <= lim) ? lz : 5'(lim);
		if (sum_s2[27]) begin
			n   = {sum_s2[27:2], sum_s2[1] | sum_s2[0]};
			e_n = {1'b0, e_s2} + 9'd1;
		end else begin
			n   = sum_s2[26:0] << sh;
			e_n = {1'b0, e_s2} - {4'd0, sh};
		end
		ovf  = (e_n >= 9'd255);
		base = 8'(e_n - 9'd1);
		mant = n[26:3];
		g    = n[2];
		st   = n[1] | n[0];
		inc  = g & (st | mant[0]);
		packed_mag = {base, 23'd0} + 31'(mant) + 31'(inc);
		priority if (cls_s2.nan) begin
			z_c = CANON_NAN;
		end else if (cls_s2.inf || ovf) begin
			z_c = {sign_s2, INF_MAG};
		end else if (sum_s2 == 28'd0) begin
			// exact cancellation gives +0; two like-signed zeros keep their sign
			z_c = {sub_s2 ? 1'b0 : sign_s2, 31'd0};
		end else begin
			z_c = {sign_s2, packed_mag};
		end
	end

	always_ff @(posedge clk) begin
		if (adv.s3) z_s3 <= z_c;
	end

	assign z = z_s3;

endmodule

[src/fast_inverse_square_root_core.sv]
// Fast reciprocal square root, binary32: guess = 0x5F375A86 - (x >> 1), then one Newton step.
// Four multipliers and one adder of three stages each, chained.
// Throughput one beat per cycle while results are taken; a stall holds only the full
// stages behind the output, so bubbles upstream still fill while the output waits.
// Reset clears the stage valid bits only; datapath registers are not reset.
module fast_inverse_square_root_core import fisr_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	fisr_operand_if.sink  operand,
	fisr_result_if.source result
);

	// Stage map (one beat per stage):
	//   1..3   half = x * 0.5
	//   4..6   hy   = half * y
	//   7..9   t    = hy * y
	//   10..12 s    = 1.5 - t
	//   13..15 r    = y * s
	// The first guess y rides alongside in its own delay line.

	logic [NUM_STAGES:1] valid_s;
	logic [NUM_STAGES:1] rdy;
	logic [31:0]         y_s [1:12];
	logic [31:0]         y0;
	logic [31:0]         half, hy, t, s;

	// A stage may load when it is empty or the stage after it loads too.
	always_comb begin
		rdy[NUM_STAGES] = !valid_s[NUM_STAGES] || result.ready;
		for (int k = NUM_STAGES - 1; k >= 1; k--) begin
			rdy[k] = !valid_s[k] || rdy[k + 1];
		end
	end

	assign operand.ready = rdy[1];
	assign result.valid  = valid_s[NUM_STAGES];

	// Advance valid bits with the data; a held stage keeps its beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else begin
			if (rdy[1]) valid_s[1] <= operand.valid;
			for (int k = 2; k <= NUM_STAGES; k++) begin
				if (rdy[k]) valid_s[k] <= valid_s[k - 1];
			end
		end
	end

	// First guess: the bit trick, wrapping modulo 2^32 for negative inputs.
	assign y0 = GUESS_MAGIC - {1'b0, operand.operand_bits[31:1]};

	always_ff @(posedge clk) begin
		if (rdy[1]) y_s[1] <= y0;
		for (int k = 2; k <= 12; k++) begin
			if (rdy[k]) y_s[k] <= y_s[k - 1];
		end
	end

	fisr_fmul u_half (
		.clk (clk),
		.adv (fisr_adv_t'({rdy[1], rdy[2], rdy[3]})),
		.a   (operand.operand_bits),
		.b   (ONE_HALF),
		.z   (half)
	);

	fisr_fmul u_hy (
		.clk (clk),
		.adv (fisr_adv_t'({rdy[4], rdy[5], rdy[6]})),
		.a   (half),
		.b   (y_s[3]),
		.z   (hy)
	);

	fisr_fmul u_t (
		.clk (clk),
		.adv (fisr_adv_t'({rdy[7], rdy[8], rdy[9]})),
		.a   (hy),
		.b   (y_s[6]),
		.z   (t)
	);

	// 1.5 - t as an add with the sign of t flipped.
	fisr_fadd u_s (
		.clk (clk),
		.adv (fisr_adv_t'({rdy[10], rdy[11], rdy[12]})),
		.a   (THREE_HALVES),
		.b   ({~t[31], t[30:0]}),
		.z   (s)
	);

	// Every unit already emits NaN in canonical form, so r needs no fixup.
	fisr_fmul u_r (
		.clk (clk),
		.adv (fisr_adv_t'({rdy[13], rdy[14], rdy[15]})),
		.a   (s),
		.b   (y_s[12]),
		.z   (result.result_bits)
	);

endmodule

[src/fisr_core_checker.sv]
// Port-level checks for fast_inverse_square_root_core, bound to the top level.
// Depends on fast_inverse_square_root_core_assert.svh.
`include "fast_inverse_square_root_core_assert.svh"

module fisr_core_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        op_ready,
	input logic        res_valid,
	input logic        res_ready,
	input logic [31:0] res_bits
);

	`FISR_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid, "result beat dropped while stalled")
	`FISR_ASSERT_NEXT(a_res_stable, res_valid && !res_ready, $stable(res_bits), "stalled result changed")
	`FISR_ASSERT_NOW(a_empty_ready, !res_valid, op_ready, "input not ready with empty output")
	`FISR_ASSERT_NOW(a_canon_nan, res_valid && res_bits[30:23] == 8'hFF && res_bits[22:0] != 23'd0, res_bits == 32'h7FC0_0000, "non-canonical NaN on result")

endmodule

bind fast_inverse_square_root_core fisr_core_checker u_fisr_core_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.op_ready  (operand.ready),
	.res_valid (result.valid),
	.res_ready (result.ready),
	.res_bits  (result.result_bits)
);

[dv/fast_inverse_square_root_core_test.sv]
// Testbench of the fast inverse square root core: random and corner operands with random stalls.
// Depends on fisr_pkg, fisr_operand_if, fisr_result_if and fast_inverse_square_root_core.
module fast_inverse_square_root_core_test;
	import fisr_pkg::*;

	logic clk;
	logic arst_n;

	fisr_operand_if operand();
	fisr_result_if  result();

	fast_inverse_square_root_core u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.operand (operand),
		.result  (result)
	);

	logic [31:0] pending_operands[$];
	logic [31:0] expected_rsqrt[$];
	int          error_count;
	bit          operand_beat;
	bit          result_beat;
	int          operand_gap;
	int          result_stall;
	int          beats_sent;

	// Widen a binary32 pattern to a double; exact for every class, subnormals included.
	function automatic real single_to_real(input logic [31:0] b);
		logic [63:0] d;
		logic [23:0] m;
		int          e;
		d = '0;
		d[63] = b[31];
		m = {1'b0, b[22:0]};
		e = b[30:23];
		if (e == 255) begin
			d[62:52] = 11'h7FF;
			d[51:29] = b[22:0];
		end else if (e == 0 && m == 0) begin
			d[62:0] = '0;
		end else begin
			if (e == 0) begin
				// Normalize a subnormal: value is m * 2^-149.
				e = 1;
				while (!m[23]) begin
					m = m << 1;
					e--;
				end
			end
			d[62:52] = 11'(e - 127 + 1023);
			d[51:29] = m[22:0];
		end
		return $bitstoreal(d);
	endfunction

	// Round a double to binary32, nearest-even, with gradual underflow.
	// A double result of one float operation rounds to the same value as the float op.
	function automatic logic [31:0] real_to_single(input real v);
		logic [63:0] d;
		logic [63:0] sig;
		logic [63:0] kept;
		logic [63:0] rem;
		logic [63:0] halfway;
		logic [31:0] mag;
		int          ue;
		int          shift;
		d = $realtobits(v);
		if (d[62:52] == 11'h7FF) begin
			if (d[51:0] != 0) return CANON_NAN;
			return {d[63], INF_MAG};
		end
		if (d[62:52] == 0) return {d[63], 31'd0};
		ue = int'(d[62:52]) - 1023;
		if (ue > 127) return {d[63], INF_MAG};
		sig = {11'd0, 1'b1, d[51:0]};
		shift = (ue >= -126) ? 29 : 29 + (-126 - ue);
		if (shift > 54) return {d[63], 31'd0};
		kept = sig >> shift;
		rem = sig & ((64'd1 << shift) - 1);
		halfway = 64'd1 << (shift - 1);
		if (rem > halfway || (rem == halfway && kept[0])) kept = kept + 1;
		// A carry out of the significand bumps the exponent, up to infinity.
		if (ue >= -126) mag = 32'((ue + 127) << 23) + 32'(kept) - 32'h0080_0000;
		else mag = 32'(kept);
		return {d[63], mag[30:0]};
	endfunction

	function automatic logic [31:0] predict_rsqrt(input logic [31:0] xb);
		real x, y, halfx, hy, t, s;
		logic [31:0] r;
		x = single_to_real(xb);
		y = single_to_real(GUESS_MAGIC - (xb >> 1));
		halfx = single_to_real(real_to_single(x * single_to_real(ONE_HALF)));
		hy = single_to_real(real_to_single(halfx * y));
		t = single_to_real(real_to_single(hy * y));
		s = single_to_real(real_to_single(single_to_real(THREE_HALVES) - t));
		r = real_to_single(y * s);
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("mismatch: %s got %h want %h at %0t", what, got, want, $time);
		error_count++;
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Sample both handshakes at the rising edge; predict on every accepted operand beat.
	always @(posedge clk) begin
		operand_beat = arst_n && operand.valid && operand.ready;
		result_beat = arst_n && result.valid && result.ready;
		if (operand_beat) expected_rsqrt.push_back(predict_rsqrt(operand.operand_bits));
		if (result_beat) begin
			if (expected_rsqrt.size() == 0) begin
				report_mismatch("unexpected result", result.result_bits, 32'd0);
			end else begin
				if (result.result_bits !== expected_rsqrt[0])
					report_mismatch("result_bits", result.result_bits, expected_rsqrt[0]);
				void'(expected_rsqrt.pop_front());
			end
		end
	end

	// Operand driver: advance on the falling edge, hold the beat until it is taken.
	always @(negedge clk) begin
		if (!arst_n) begin
			operand.valid <= 1'b0;
		end else if (!operand.valid || operand_beat) begin
			if (operand_gap > 0) begin
				operand_gap--;
				operand.valid <= 1'b0;
			end else if (pending_operands.size() != 0) begin
				operand.operand_bits <= pending_operands.pop_front();
				operand.valid <= 1'b1;
				beats_sent++;
				// Every few hundred beats, run a stretch with no gaps at all.
				operand_gap = ((beats_sent / 150) % 3 == 1) ? 0 : $urandom_range(0, 3);
			end else begin
				operand.valid <= 1'b0;
			end
		end
	end

	// Result sink: draw a stall per result, drop ready while it runs out.
	always @(negedge clk) begin
		if (!arst_n) begin
			result.ready <= 1'b0;
		end else begin
			if (result_beat)
				result_stall = ((beats_sent / 150) % 3 == 1) ? 0 : $urandom_range(0, 3);
			if (result_stall > 0) begin
				result_stall--;
				result.ready <= 1'b0;
			end else begin
				result.ready <= 1'b1;
			end
		end
	end

	initial begin
		logic [31:0] v;
		operand.valid = 1'b0;
		operand.operand_bits = '0;
		result.ready = 1'b0;
		arst_n = 1'b0;
		error_count = 0;
		operand_gap = 0;
		result_stall = 0;
		beats_sent = 0;

		// Corners: signed zeros, infinities, NaNs, subnormal and normal extremes.
		pending_operands.push_back(32'h0000_0000);
		pending_operands.push_back(32'h8000_0000);
		pending_operands.push_back(32'h7F80_0000);
		pending_operands.push_back(32'hFF80_0000);
		pending_operands.push_back(32'h7FC0_0000);
		pending_operands.push_back(32'h7F80_0001);
		pending_operands.push_back(32'hFFFF_FFFF);
		pending_operands.push_back(32'h7FFF_FFFF);
		pending_operands.push_back(32'h0000_0001);
		pending_operands.push_back(32'h007F_FFFF);
		pending_operands.push_back(32'h0080_0000);
		pending_operands.push_back(32'h7F7F_FFFF);
		pending_operands.push_back(32'h3F80_0000);
		pending_operands.push_back(32'h4080_0000);
		pending_operands.push_back(32'h3E80_0000);
		pending_operands.push_back(32'h4000_0000);
		pending_operands.push_back(32'hBF80_0000);
		pending_operands.push_back(32'h8000_0001);
		pending_operands.push_back(32'hFF7F_FFFF);
		pending_operands.push_back(32'h5F37_5A86);
		pending_operands.push_back(32'h0000_0002);
		pending_operands.push_back(32'h8080_0000);

		// Random: mostly positive values, plus subnormals and raw patterns of any sign.
		for (int i = 0; i < 1300; i++) begin
			case ($urandom_range(0, 9))
				0, 1: v = $urandom();
				2:    v = {1'b0, 8'd0, 23'($urandom())};
				3:    v = {1'($urandom()), 8'($urandom_range(250, 255)), 23'($urandom())};
				default: v = {1'b0, 8'($urandom_range(1, 254)), 23'($urandom())};
			endcase
			pending_operands.push_back(v);
		end

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		wait (pending_operands.size() == 0);
		@(posedge clk);
		while (operand.valid) @(posedge clk);
		while (expected_rsqrt.size() != 0) @(posedge clk);
		// Let any stray result past the pipeline depth show up.
		repeat (NUM_STAGES + 10) @(posedge clk);
		if (error_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	initial begin
		#1000000;
		$display("tb: failure");
		$finish;
	end

endmodule
